/* src/otb_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the one-shot timer bank.
// No dependencies; imported by one_shot_timer_bank.
package otb_pkg;

  localparam int TIMER_SLOTS_DEF = 16;

  localparam logic FUNC_ADD  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam logic [1:0] ST_ACCEPTED = 2'd0;
  localparam logic [1:0] ST_REFUSED  = 2'd1;
  localparam logic [1:0] ST_EXPIRED  = 2'd2;

  typedef struct packed {
    logic        func;
    logic [15:0] handle;
    logic [31:0] duration;
    logic [31:0] elapsed;
  } otb_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] expired_handle;
    logic [31:0] overshoot;
    logic        last;
  } otb_out_t;

endpackage

/* src/one_shot_timer_bank.sv */
`timescale 1ns / 1ps
// One-shot timer bank, timers kept oldest first in a slot memory.
// Add: answer is registered from S_ANSWER once the output is free; input ready again when it is loaded.
// Tick: per slot, S_READ then S_EVAL; S_FLUSH sends a held expiry at the end; one shared
// subtract/compare unit walks the slots via the memory's registered read port.
// Results back-pressure the walk and the answer; one expiry is held back to mark the last.
// Synchronous active-high reset empties the bank; slot contents are not cleared.
module one_shot_timer_bank
  import otb_pkg::*;
#(
  parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  otb_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output otb_out_t out_data
);

  localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CW = $clog2(TIMER_SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ANSWER,
    S_READ,
    S_EVAL,
    S_FLUSH
  } state_t;

  state_t         state;
  logic [CW-1:0]  live_count;
  logic [CW-1:0]  idx;
  logic [CW-1:0]  keep;
  logic [31:0]    elapsed;
  logic [1:0]     ans_status;
  logic           pend_valid;
  otb_out_t       pend;

  // slot memory
  logic [15:0]    mem_handle [TIMER_SLOTS];
  logic [31:0]    mem_remain [TIMER_SLOTS];
  logic [15:0]    rd_handle;
  logic [31:0]    rd_remain;

  logic           we;
  logic [IW-1:0]  waddr;
  logic [15:0]    wdata_handle;
  logic [31:0]    wdata_remain;

  logic           out_free;
  logic           out_load;
  logic           expire;
  logic           stall;
  logic           full;
  logic [CW-1:0]  idx_inc;
  logic [CW-1:0]  keep_next;

  assign in_ready  = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;
  assign full      = (live_count == CW'(TIMER_SLOTS));
  assign expire    = (elapsed >= rd_remain);
  assign stall     = expire && pend_valid && !out_free;
  assign idx_inc   = idx + CW'(1);
  assign keep_next = expire ? keep : keep + CW'(1);
  // a new result enters the output register this cycle
  assign out_load  = ((state == S_ANSWER || state == S_FLUSH) && out_free) ||
                     (state == S_EVAL && !stall && expire && pend_valid);

  always_comb begin
    we           = 1'b0;
    waddr        = live_count[IW-1:0];
    wdata_handle = in_data.handle;
    wdata_remain = in_data.duration;
    if (state == S_IDLE && in_valid && in_data.func == FUNC_ADD && !full) begin
      we = 1'b1;
    end else if (state == S_EVAL && !expire) begin
      // survivor closes up toward the front; keep never passes idx
      we           = 1'b1;
      waddr        = keep[IW-1:0];
      wdata_handle = rd_handle;
      wdata_remain = rd_remain - elapsed;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_handle[waddr] <= wdata_handle;
      mem_remain[waddr] <= wdata_remain;
    end
    if (state == S_READ) begin
      rd_handle <= mem_handle[idx[IW-1:0]];
      rd_remain <= mem_remain[idx[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      live_count <= '0;
      idx        <= '0;
      keep       <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (in_data.func == FUNC_ADD) begin
              ans_status <= full ? ST_REFUSED : ST_ACCEPTED;
              if (!full) begin
                live_count <= live_count + CW'(1);
              end
              state <= S_ANSWER;
            end else begin
              elapsed    <= in_data.elapsed;
              idx        <= '0;
              keep       <= '0;
              pend_valid <= 1'b0;
              state      <= (live_count == '0) ? S_IDLE : S_READ;
            end
          end
        end
        S_ANSWER: begin
          if (out_free) begin
            out_data.status          <= ans_status;
            out_data.expired_handle  <= '0;
            out_data.overshoot       <= '0;
            out_data.last            <= 1'b1;
            state                    <= S_IDLE;
          end
        end
        S_READ: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (!stall) begin
            if (expire) begin
              if (pend_valid) begin
                out_data <= pend;
              end
              pend.status         <= ST_EXPIRED;
              pend.expired_handle <= rd_handle;
              pend.overshoot      <= elapsed - rd_remain;
              pend.last           <= 1'b0;
              pend_valid          <= 1'b1;
            end
            keep <= keep_next;
            idx  <= idx_inc;
            if (idx_inc == live_count) begin
              live_count <= keep_next;
              state      <= (pend_valid || expire) ? S_FLUSH : S_IDLE;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            out_data.status         <= pend.status;
            out_data.expired_handle <= pend.expired_handle;
            out_data.overshoot      <= pend.overshoot;
            out_data.last           <= 1'b1;
            pend_valid              <= 1'b0;
            state                   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    live_count <= CW'(TIMER_SLOTS))
    else $error("live timer count above slot count");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !pend_valid)
    else $error("held expiry left behind at end of tick");

  a_compact_order: assert property (@(posedge clk) disable iff (rst)
    state == S_EVAL |-> keep <= idx)
    else $error("compaction write would pass read pointer");

  a_full_refuse: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.func == FUNC_ADD && full
    |=> live_count == $past(live_count) && ans_status == ST_REFUSED)
    else $error("add to a full bank changed the bank");

  a_answer_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == ST_ACCEPTED || out_data.status == ST_REFUSED)
    |-> out_data.last)
    else $error("add answer not marked last");

endmodule

/* bench/one_shot_timer_bank_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for one_shot_timer_bank: directed and random add/tick traffic.
// Needs otb_pkg and one_shot_timer_bank; the scoreboard below predicts every result.
module one_shot_timer_bank_tb;
  import otb_pkg::*;

  localparam int MAX_REPORTS   = 10;
  localparam int RANDOM_ITEMS  = 480;
  localparam int DRAIN_CYCLES  = 2 * TIMER_SLOTS_DEF + 10;
  localparam int QUIET_FIRST   = 200;
  localparam int QUIET_LAST    = 299;

  class timer_scoreboard;
    logic [15:0] slot_handle_q[TIMER_SLOTS_DEF];
    logic [31:0] slot_left[TIMER_SLOTS_DEF];
    int unsigned live;
    otb_out_t    expected_q[$];
    int unsigned mismatches;
    int unsigned inputs_seen;
    int unsigned results_seen;
    int unsigned expiries;
    int unsigned refusals;

    function new();
      live         = 0;
      mismatches   = 0;
      inputs_seen  = 0;
      results_seen = 0;
      expiries     = 0;
      refusals     = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Apply one accepted input transaction to the shadow bank.
    function void note_input(otb_in_t t);
      otb_out_t    r;
      int unsigned keep;
      int unsigned first_new;
      int unsigned i;
      r = '0;
      inputs_seen++;
      if (t.func == FUNC_ADD) begin
        r.last = 1'b1;
        if (live >= TIMER_SLOTS_DEF) begin
          r.status = ST_REFUSED;
        end else begin
          slot_handle_q[live] = t.handle;
          slot_left[live]     = t.duration;
          live++;
          r.status = ST_ACCEPTED;
        end
        expected_q.push_back(r);
      end else begin
        keep      = 0;
        first_new = expected_q.size();
        for (i = 0; i < live; i++) begin
          if (t.elapsed >= slot_left[i]) begin
            r.status         = ST_EXPIRED;
            r.expired_handle = slot_handle_q[i];
            r.overshoot      = t.elapsed - slot_left[i];
            r.last           = 1'b0;
            expected_q.push_back(r);
          end else begin
            slot_handle_q[keep] = slot_handle_q[i];
            slot_left[keep]     = slot_left[i] - t.elapsed;
            keep++;
          end
        end
        live = keep;
        if (expected_q.size() > first_new) begin
          r      = expected_q[expected_q.size() - 1];
          r.last = 1'b1;
          expected_q[expected_q.size() - 1] = r;
        end
      end
    endfunction

    function void check_result(otb_out_t got);
      otb_out_t want;
      results_seen++;
      if (got.status == ST_EXPIRED) expiries++;
      if (got.status == ST_REFUSED) refusals++;
      if (expected_q.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: unexpected result status=%0d handle=%h overshoot=%h last=%b",
                   $realtime, got.status, got.expired_handle, got.overshoot, got.last);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status || got.expired_handle !== want.expired_handle ||
          got.overshoot !== want.overshoot || got.last !== want.last) begin
        if (mismatches < MAX_REPORTS) begin
          $display("%0t: result mismatch", $realtime);
          $display("  status   exp %0d got %0d", want.status, got.status);
          $display("  handle   exp %h got %h", want.expired_handle, got.expired_handle);
          $display("  overshoot exp %h got %h", want.overshoot, got.overshoot);
          $display("  last     exp %b got %b", want.last, got.last);
        end
        mismatches++;
      end
    endfunction
  endclass

  logic     clk;
  logic     rst;
  logic     in_valid;
  logic     in_ready;
  otb_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  otb_out_t out_data;
  logic     quiet;

  timer_scoreboard sb;

  one_shot_timer_bank u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Sink side: ready drops about a quarter of the time outside the quiet stretch.
  always @(posedge clk) begin
    out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 25);
  end

  // Monitor: both channels sampled at the edge where a transaction completes.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_result(out_data);
      if (in_valid && in_ready) sb.note_input(in_data);
    end
  end

  function automatic otb_in_t make_item(logic f, logic [15:0] h, logic [31:0] d,
                                        logic [31:0] e);
    otb_in_t t;
    t.func     = f;
    t.handle   = h;
    t.duration = d;
    t.elapsed  = e;
    return t;
  endfunction

  // Mostly short spans so timers live a few ticks; some zero and full-range values.
  function automatic logic [31:0] rand_span(int unsigned short_max);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) return 32'd0;
    else if (pick < 20) return $urandom();
    else if (pick < 30) return $urandom_range(short_max * 8);
    else return $urandom_range(short_max);
  endfunction

  task automatic send_item(otb_in_t t);
    if (!quiet) begin
      while ($urandom_range(99) < 25) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold off input until every predicted result is out, then let a tick walk finish.
  // The extra edge lets the monitor record the last accepted input first.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [31:0] fill_dur[TIMER_SLOTS_DEF];
    int          k;
    sb        = new();
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    quiet     = 1'b0;
    fill_dur  = '{32'd1, 32'd10, 32'd5, 32'hFFFF_FFFF, 32'd0, 32'd100, 32'd7, 32'd3,
                  32'h8000_0000, 32'd6, 32'd2, 32'h7FFF_FFFF, 32'd4, 32'd50, 32'd5, 32'd9};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty tick, zero duration, exact expiry, full bank, max results.
    send_item(make_item(FUNC_TICK, 16'h0000, 32'd0, 32'd0));
    send_item(make_item(FUNC_ADD, 16'h0000, 32'd0, 32'hFFFF_FFFF));
    send_item(make_item(FUNC_TICK, 16'hFFFF, 32'hFFFF_FFFF, 32'd0));
    send_item(make_item(FUNC_ADD, 16'hABCD, 32'd1000, 32'd0));
    send_item(make_item(FUNC_TICK, 16'h0000, 32'd0, 32'd10));
    send_item(make_item(FUNC_TICK, 16'h0000, 32'd0, 32'd990));
    for (k = 0; k < TIMER_SLOTS_DEF; k++)
      send_item(make_item(FUNC_ADD, 16'(k * 16'h1111), fill_dur[k], 32'd0));
    send_item(make_item(FUNC_ADD, 16'h5A5A, 32'd1, 32'd0));
    send_item(make_item(FUNC_TICK, 16'h0000, 32'd0, 32'd5));
    send_item(make_item(FUNC_TICK, 16'h0000, 32'd0, 32'hFFFF_FFFF));

    for (k = 0; k < RANDOM_ITEMS; k++) begin
      quiet = (k >= QUIET_FIRST && k <= QUIET_LAST);
      if (k == 120 || k == 360) wait_for_drain();
      send_item(make_item(($urandom_range(99) < 58) ? FUNC_ADD : FUNC_TICK,
                          16'($urandom_range(16'hFFFF)), rand_span(2000), rand_span(400)));
    end
    quiet = 1'b0;

    wait_for_drain();
    $display("Sent %0d transactions; checked %0d results (%0d expiries, %0d refusals).",
             sb.inputs_seen, sb.results_seen, sb.expiries, sb.refusals);
    $display("Mismatch count: %0d, results still outstanding: %0d.",
             sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout waiting for the bank to drain");
    $display("Mismatches found");
    $finish;
  end

endmodule
